/* design/anbs_pkg.sv */
// shared types, constants and helpers for the annex b nal unit splitter
// no dependencies
`timescale 1ns / 1ps

package anbs_pkg;

    localparam int unsigned MAX_UNIT_BYTES = 1048576;
    localparam int unsigned CNT_W          = $clog2(MAX_UNIT_BYTES + 1);
    localparam int unsigned LEN_W          = 21;
    localparam int unsigned LEN_MAX        = (2 ** LEN_W) - 1;
    localparam int unsigned CQ_DEPTH       = 4;
    localparam int unsigned CQ_AW          = $clog2(CQ_DEPTH);

    localparam logic [7:0] ZERO_BYTE  = 8'h00;
    localparam logic [7:0] START_BYTE = 8'h01;
    localparam logic [1:0] HELD_MAX   = 2'd3;
    localparam logic [1:0] HELD_SHORT = 2'd2;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_END     = 1'b1;

    typedef logic [CNT_W-1:0] t_cnt;

    // one queue entry: zero bytes, then an optional data byte, then an optional end record
    typedef struct packed {
        logic [2:0]       nzeros;
        logic             has_byte;
        logic [7:0]       data;
        logic             first;
        logic             end_rec;
        logic [5:0]       utype;
        logic             forb;
        logic             long_sc;
        logic [LEN_W-1:0] len;
        logic             ovf;
    } t_cmd;

    function automatic logic [LEN_W-1:0] cap_len(input t_cnt cnt);
        logic [31:0] wide;
        wide = 32'(cnt);
        if (wide > 32'(LEN_MAX)) begin
            return LEN_W'(LEN_MAX);
        end
        return LEN_W'(cnt);
    endfunction

endpackage

/* design/anbs_front.sv */
// front end: start code search, zero hold-back and unit bookkeeping
// depends on anbs_pkg
`timescale 1ns / 1ps

module anbs_front import anbs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_stream_byte,
    input  logic       i_end_of_stream,
    output logic       o_cmd_push,
    output t_cmd       o_cmd
);

    logic [1:0] r_held, n_held;
    logic       r_inside, n_inside;
    logic       r_expect, n_expect;
    t_cnt       r_count, n_count;
    logic [5:0] r_type, n_type;
    logic       r_forb, n_forb;
    logic       r_long, n_long;
    logic       r_sat, n_sat;

    logic             is_sc;
    logic             hasb;
    logic [2:0]       zeros_now;
    logic [2:0]       nz;
    logic [2:0]       k;
    logic [CNT_W:0]   sum;
    logic             first;
    logic             end_last;
    logic             push;
    t_cmd             cmd;

    always_comb begin
        n_held    = r_held;
        n_inside  = r_inside;
        n_expect  = r_expect;
        n_count   = r_count;
        n_type    = r_type;
        n_forb    = r_forb;
        n_long    = r_long;
        n_sat     = r_sat;
        is_sc     = 1'b0;
        hasb      = 1'b0;
        zeros_now = 3'd0;
        nz        = 3'd0;
        k         = 3'd0;
        sum       = '0;
        first     = 1'b0;
        end_last  = 1'b0;
        push      = 1'b0;
        cmd       = '0;

        priority if (i_stream_byte == ZERO_BYTE) begin
            if (r_held < HELD_MAX) begin
                n_held = r_held + 2'd1;
            end else begin
                // fourth zero: the oldest held zero goes out
                zeros_now = 3'd1;
            end
        end else if (i_stream_byte == START_BYTE && r_held >= HELD_SHORT) begin
            is_sc = 1'b1;
        end else begin
            zeros_now = {1'b0, r_held};
            hasb      = 1'b1;
            n_held    = 2'd0;
        end

        if (is_sc) begin
            push         = r_inside;
            cmd.end_rec  = 1'b1;
            cmd.utype    = r_type;
            cmd.forb     = r_forb;
            cmd.long_sc  = r_long;
            cmd.len      = cap_len(r_count);
            cmd.ovf      = r_sat;
            n_inside     = 1'b1;
            n_expect     = 1'b1;
            n_long       = (r_held == HELD_MAX);
            n_count      = '0;
            n_sat        = 1'b0;
            n_type       = 6'd0;
            n_forb       = 1'b0;
            n_held       = 2'd0;
        end else begin
            // stream end releases the zeros still held
            nz = zeros_now + (i_end_of_stream ? {1'b0, n_held} : 3'd0);
            if (r_inside) begin
                k = nz + {2'b00, hasb};
            end
            sum     = {1'b0, r_count} + (CNT_W + 1)'(k);
            n_count = (sum > (CNT_W + 1)'(MAX_UNIT_BYTES)) ? t_cnt'(MAX_UNIT_BYTES)
                                                           : sum[CNT_W-1:0];
            n_sat   = r_sat | (sum > (CNT_W + 1)'(MAX_UNIT_BYTES));
            first   = r_expect && (k != 3'd0);
            if (first) begin
                // the header is a zero when zeros come out ahead of the byte
                n_type = (nz != 3'd0) ? 6'd0 : i_stream_byte[6:1];
                n_forb = (nz != 3'd0) ? 1'b0 : i_stream_byte[7];
            end
            n_expect     = r_expect && (k == 3'd0);
            end_last     = i_end_of_stream && r_inside && (!r_expect || (k != 3'd0));
            push         = r_inside && ((k != 3'd0) || end_last);
            cmd.nzeros   = nz;
            cmd.has_byte = hasb;
            cmd.data     = i_stream_byte;
            cmd.first    = first;
            cmd.end_rec  = end_last;
            cmd.utype    = n_type;
            cmd.forb     = n_forb;
            cmd.long_sc  = r_long;
            cmd.len      = cap_len(n_count);
            cmd.ovf      = n_sat;
        end

        if (i_end_of_stream) begin
            n_held   = 2'd0;
            n_inside = 1'b0;
            n_expect = 1'b0;
            n_count  = '0;
            n_type   = 6'd0;
            n_forb   = 1'b0;
            n_long   = 1'b0;
            n_sat    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held   <= 2'd0;
            r_inside <= 1'b0;
            r_expect <= 1'b0;
            r_count  <= '0;
            r_type   <= 6'd0;
            r_forb   <= 1'b0;
            r_long   <= 1'b0;
            r_sat    <= 1'b0;
        end else if (i_accept) begin
            r_held   <= n_held;
            r_inside <= n_inside;
            r_expect <= n_expect;
            r_count  <= n_count;
            r_type   <= n_type;
            r_forb   <= n_forb;
            r_long   <= n_long;
            r_sat    <= n_sat;
        end
    end

    assign o_cmd_push = i_accept && push;
    assign o_cmd      = cmd;

endmodule

/* design/anbs_cmd_fifo.sv */
// small command queue between front end and record generator
// depends on anbs_pkg
`timescale 1ns / 1ps

module anbs_cmd_fifo import anbs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd             r_mem [CQ_DEPTH];
    logic [CQ_AW-1:0] r_wr;
    logic [CQ_AW-1:0] r_rd;
    logic [CQ_AW:0]   r_cnt;
    logic             do_pop;

    assign o_full  = (r_cnt == (CQ_AW + 1)'(CQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (CQ_AW + 1)'(i_push) - (CQ_AW + 1)'(do_pop);
        end
    end

endmodule

/* design/anbs_back.sv */
// record generator: expands one queued command into records, one per cycle while the output slot is free or popped
// depends on anbs_pkg
`timescale 1ns / 1ps

module anbs_back import anbs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    input  t_cmd             i_cmd,
    output logic             o_cmd_pop,
    input  logic             i_pop,
    output logic             o_empty,
    output logic             o_record_kind,
    output logic [7:0]       o_payload_byte,
    output logic             o_first_of_unit,
    output logic [5:0]       o_unit_type,
    output logic             o_forbidden_flag,
    output logic             o_long_start_code,
    output logic [LEN_W-1:0] o_unit_length,
    output logic             o_length_overflow,
    output logic             o_last_of_run
);

    logic [2:0]       r_step;
    logic             r_valid;
    logic             r_kind;
    logic [7:0]       r_byte;
    logic             r_first;
    logic [5:0]       r_type;
    logic             r_forb;
    logic             r_long;
    logic [LEN_W-1:0] r_len;
    logic             r_ovf;
    logic             r_last;

    logic       take;
    logic [2:0] nrec;
    logic       is_zero;
    logic       is_byte;
    logic       is_last;

    assign nrec    = i_cmd.nzeros + {2'b00, i_cmd.has_byte} + {2'b00, i_cmd.end_rec};
    assign is_zero = (r_step < i_cmd.nzeros);
    assign is_byte = !is_zero && i_cmd.has_byte && (r_step == i_cmd.nzeros);
    assign is_last = (r_step == nrec - 3'd1);
    // output slot free or being emptied this cycle
    assign take      = i_cmd_valid && (!r_valid || i_pop);
    assign o_cmd_pop = take && is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= 3'd0;
            r_valid <= 1'b0;
        end else begin
            if (take) begin
                r_step  <= is_last ? 3'd0 : r_step + 3'd1;
                r_valid <= 1'b1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_kind  <= (is_zero || is_byte) ? KIND_PAYLOAD : KIND_END;
            r_byte  <= is_byte ? i_cmd.data : ZERO_BYTE;
            r_first <= i_cmd.first && (r_step == 3'd0) && (is_zero || is_byte);
            r_type  <= i_cmd.utype;
            r_forb  <= i_cmd.forb;
            r_long  <= i_cmd.long_sc;
            r_len   <= (is_zero || is_byte) ? '0 : i_cmd.len;
            r_ovf   <= (is_zero || is_byte) ? 1'b0 : i_cmd.ovf;
            r_last  <= is_last;
        end
    end

    assign o_empty           = !r_valid;
    assign o_record_kind     = r_kind;
    assign o_payload_byte    = r_byte;
    assign o_first_of_unit   = r_first;
    assign o_unit_type       = r_type;
    assign o_forbidden_flag  = r_forb;
    assign o_long_start_code = r_long;
    assign o_unit_length     = r_len;
    assign o_length_overflow = r_ovf;
    assign o_last_of_run     = r_last;

endmodule

/* design/annexb_nal_unit_splitter.sv */
// Annex B NAL unit splitter: takes one stream byte per cycle and returns payload and end
// records. The front end classifies each accepted byte in the same cycle and, when the byte
// causes records, leaves one command in a 4-entry queue; the back end turns a command into
// 1 to 5 records at one record per cycle into the output register while it is free or
// popped; a byte's first record passes through the queue and the output register before it
// shows on the result ports. Input runs at one byte per cycle while the queue has room;
// full rises when bursts of records (held zeros flushed ahead of a byte, end records) or a
// stalled pop keep the back end behind the front end. Pops may follow every cycle.
// depends on anbs_pkg, anbs_front, anbs_cmd_fifo, anbs_back
`timescale 1ns / 1ps

module annexb_nal_unit_splitter import anbs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  logic [7:0]       i_stream_byte,
    input  logic             i_end_of_stream,
    output logic             empty,
    input  logic             pop,
    output logic             o_record_kind,
    output logic [7:0]       o_payload_byte,
    output logic             o_first_of_unit,
    output logic [5:0]       o_unit_type,
    output logic             o_forbidden_flag,
    output logic             o_long_start_code,
    output logic [LEN_W-1:0] o_unit_length,
    output logic             o_length_overflow,
    output logic             o_last_of_run
);

    logic accept;
    logic cmd_push;
    t_cmd cmd_in;
    logic cmd_valid;
    t_cmd cmd_out;
    logic cmd_pop;

    assign accept = push && !full;

    anbs_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_stream_byte   (i_stream_byte),
        .i_end_of_stream (i_end_of_stream),
        .o_cmd_push      (cmd_push),
        .o_cmd           (cmd_in)
    );

    anbs_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .o_full  (full),
        .i_pop   (cmd_pop),
        .o_valid (cmd_valid),
        .o_cmd   (cmd_out)
    );

    anbs_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd_valid       (cmd_valid),
        .i_cmd             (cmd_out),
        .o_cmd_pop         (cmd_pop),
        .i_pop             (pop),
        .o_empty           (empty),
        .o_record_kind     (o_record_kind),
        .o_payload_byte    (o_payload_byte),
        .o_first_of_unit   (o_first_of_unit),
        .o_unit_type       (o_unit_type),
        .o_forbidden_flag  (o_forbidden_flag),
        .o_long_start_code (o_long_start_code),
        .o_unit_length     (o_unit_length),
        .o_length_overflow (o_length_overflow),
        .o_last_of_run     (o_last_of_run)
    );

    // end records carry no byte and are never the header
    a_end_rec_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_record_kind == KIND_END) |-> (o_payload_byte == ZERO_BYTE && !o_first_of_unit))
        else $error("end record carries payload fields");

    // payload records carry no length information
    a_payload_no_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_record_kind == KIND_PAYLOAD) |-> (o_unit_length == '0 && !o_length_overflow))
        else $error("payload record carries length fields");

    // an overflowing unit reports the saturated count
    a_ovf_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_length_overflow) |-> (o_unit_length == cap_len(t_cnt'(MAX_UNIT_BYTES))))
        else $error("overflow without saturated length");

    // no record appears while the queue holds no command and nothing is pushed
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!cmd_valid && empty && !cmd_push) |=> empty)
        else $error("record appeared without a queued command");

endmodule

/* tb/sv/testbench.sv */
// self-checking testbench for annexb_nal_unit_splitter: directed stream table, then random
// annex b streams under several handshake pressure phases, checked against a local predictor
// depends on anbs_pkg and annexb_nal_unit_splitter
`timescale 1ns / 1ps

module testbench;
    import anbs_pkg::*;

    localparam int STALL_LIMIT   = 5000;
    localparam int PHASE_BYTES   = 50;
    localparam int MAX_SHOWN     = 10;
    localparam int TAIL_CYCLES   = 20;

    // one output record of the splitter
    typedef struct packed {
        logic             kind;
        logic [7:0]       data;
        logic             first;
        logic [5:0]       utype;
        logic             forb;
        logic             long_sc;
        logic [LEN_W-1:0] len;
        logic             ovf;
        logic             last;
    } t_nal_rec;

    // one directed stream row; n counts the records of its last byte, later fields describe the last
    typedef struct packed {
        logic [7:0] sb;
        logic       eos;
        int         rep;
        logic       chk;
        int         n;
        logic       kind;
        logic [7:0] data;
        int         len;
        logic       ovf;
    } t_stream_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             push = 1'b0;
    logic             full;
    logic [7:0]       i_stream_byte = 8'h00;
    logic             i_end_of_stream = 1'b0;
    logic             empty;
    logic             pop = 1'b0;
    logic             o_record_kind;
    logic [7:0]       o_payload_byte;
    logic             o_first_of_unit;
    logic [5:0]       o_unit_type;
    logic             o_forbidden_flag;
    logic             o_long_start_code;
    logic [LEN_W-1:0] o_unit_length;
    logic             o_length_overflow;
    logic             o_last_of_run;

    annexb_nal_unit_splitter u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_stream_byte     (i_stream_byte),
        .i_end_of_stream   (i_end_of_stream),
        .empty             (empty),
        .pop               (pop),
        .o_record_kind     (o_record_kind),
        .o_payload_byte    (o_payload_byte),
        .o_first_of_unit   (o_first_of_unit),
        .o_unit_type       (o_unit_type),
        .o_forbidden_flag  (o_forbidden_flag),
        .o_long_start_code (o_long_start_code),
        .o_unit_length     (o_unit_length),
        .o_length_overflow (o_length_overflow),
        .o_last_of_run     (o_last_of_run)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // splitter state mirrored by the predictor
    logic [1:0] pr_held;
    logic       pr_inside;
    logic       pr_hdr;
    t_cnt       pr_count;
    logic [5:0] pr_type;
    logic       pr_forb;
    logic       pr_long;
    logic       pr_sat;

    t_nal_rec    pending_recs[$];
    t_nal_rec    byte_recs[$];
    t_stream_row stream_table[$];
    logic [7:0]  chunk[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatches     = 0;
    int bytes_directed = 0;
    int bytes_random   = 0;
    int recs_checked   = 0;
    int ends_checked   = 0;
    int idle_cycles    = 0;

    task automatic clear_splitter_state();
        pr_held   = 2'd0;
        pr_inside = 1'b0;
        pr_hdr    = 1'b0;
        pr_count  = '0;
        pr_type   = 6'd0;
        pr_forb   = 1'b0;
        pr_long   = 1'b0;
        pr_sat    = 1'b0;
    endtask

    task automatic put_payload(input logic [7:0] b);
        t_nal_rec rec;
        if (pr_inside) begin
            rec.first = pr_hdr;
            if (pr_hdr) begin
                pr_type = b[6:1];
                pr_forb = b[7];
                pr_hdr  = 1'b0;
            end
            if (pr_count < t_cnt'(MAX_UNIT_BYTES)) begin
                pr_count = pr_count + 1'b1;
            end else begin
                pr_sat = 1'b1;
            end
            rec.kind    = KIND_PAYLOAD;
            rec.data    = b;
            rec.utype   = pr_type;
            rec.forb    = pr_forb;
            rec.long_sc = pr_long;
            rec.len     = '0;
            rec.ovf     = 1'b0;
            rec.last    = 1'b0;
            byte_recs.push_back(rec);
        end
    endtask

    task automatic put_end_record();
        t_nal_rec rec;
        rec.kind    = KIND_END;
        rec.data    = 8'h00;
        rec.first   = 1'b0;
        rec.utype   = pr_type;
        rec.forb    = pr_forb;
        rec.long_sc = pr_long;
        rec.len     = (32'(pr_count) > 32'(LEN_MAX)) ? LEN_W'(LEN_MAX) : LEN_W'(pr_count);
        rec.ovf     = pr_sat;
        rec.last    = 1'b0;
        byte_recs.push_back(rec);
    endtask

    task automatic release_held_zeros();
        while (pr_held != 2'd0) begin
            put_payload(ZERO_BYTE);
            pr_held = pr_held - 2'd1;
        end
    endtask

    // records caused by one stream byte, left in byte_recs and appended to pending_recs
    task automatic predict_byte(input logic [7:0] b, input logic e);
        t_nal_rec tail;
        byte_recs.delete();
        if (b == ZERO_BYTE) begin
            if (pr_held < HELD_MAX) begin
                pr_held = pr_held + 2'd1;
            end else begin
                put_payload(ZERO_BYTE);
            end
        end else if (b == START_BYTE && pr_held >= HELD_SHORT) begin
            if (pr_inside) begin
                put_end_record();
            end
            pr_inside = 1'b1;
            pr_hdr    = 1'b1;
            pr_long   = (pr_held == HELD_MAX);
            pr_count  = '0;
            pr_sat    = 1'b0;
            pr_type   = 6'd0;
            pr_forb   = 1'b0;
            pr_held   = 2'd0;
        end else begin
            release_held_zeros();
            put_payload(b);
        end
        if (e) begin
            if (pr_inside) begin
                release_held_zeros();
                // a start code right before the stream end leaves no record
                if (!pr_hdr) begin
                    put_end_record();
                end
            end
            clear_splitter_state();
        end
        if (byte_recs.size() > 0) begin
            tail = byte_recs.pop_back();
            tail.last = 1'b1;
            byte_recs.push_back(tail);
        end
        foreach (byte_recs[k]) begin
            pending_recs.push_back(byte_recs[k]);
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic e);
        @(negedge i_clk);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push            <= 1'b1;
        i_stream_byte   <= b;
        i_end_of_stream <= e;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        predict_byte(b, e);
    endtask

    // hold the input off until every predicted record has been popped
    task automatic drain_results();
        @(negedge i_clk);
        push <= 1'b0;
        while (pending_recs.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic add_row(input logic [7:0] sb, input logic eos, input int rep,
                           input logic chk, input int n, input logic kind,
                           input logic [7:0] data, input int len, input logic ovf);
        t_stream_row row;
        row = '{sb, eos, rep, chk, n, kind, data, len, ovf};
        stream_table.push_back(row);
    endtask

    function automatic logic [7:0] biased_byte();
        int r;
        r = $urandom_range(99, 0);
        if (r < 30) begin
            return ZERO_BYTE;
        end else if (r < 36) begin
            return START_BYTE;
        end else if (r < 40) begin
            return 8'h03;
        end
        return 8'($urandom_range(255, 0));
    endfunction

    // one piece of random stream: mostly whole units, some empty units, noise and broken codes
    task automatic build_chunk();
        int c;
        int nz;
        int len;
        chunk.delete();
        c = $urandom_range(99, 0);
        if (c < 65) begin
            nz = ($urandom_range(9, 0) == 0) ? 4 : $urandom_range(3, 2);
            repeat (nz) chunk.push_back(ZERO_BYTE);
            chunk.push_back(START_BYTE);
            chunk.push_back(8'($urandom_range(255, 0)));
            len = $urandom_range(12, 0);
            repeat (len) chunk.push_back(biased_byte());
        end else if (c < 75) begin
            chunk.push_back(ZERO_BYTE);
            chunk.push_back(ZERO_BYTE);
            chunk.push_back(START_BYTE);
        end else if (c < 90) begin
            len = $urandom_range(5, 1);
            repeat (len) chunk.push_back(biased_byte());
        end else begin
            // start code that falls apart
            chunk.push_back(ZERO_BYTE);
            if ($urandom_range(1, 0) == 1) begin
                chunk.push_back(ZERO_BYTE);
                chunk.push_back(8'($urandom_range(255, 2)));
            end else begin
                chunk.push_back(START_BYTE);
            end
        end
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_nal_rec want;
        if (i_rst_n && pop && !empty) begin
            recs_checked++;
            if (o_record_kind === KIND_END) begin
                ends_checked++;
            end
            if (pending_recs.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN) begin
                    $display("%0t: unexpected record kind=%0d byte=%02h len=%0d", $realtime,
                             o_record_kind, o_payload_byte, o_unit_length);
                end
            end else begin
                want = pending_recs.pop_front();
                if (o_record_kind !== want.kind || o_payload_byte !== want.data ||
                    o_first_of_unit !== want.first || o_unit_type !== want.utype ||
                    o_forbidden_flag !== want.forb || o_long_start_code !== want.long_sc ||
                    o_unit_length !== want.len || o_length_overflow !== want.ovf ||
                    o_last_of_run !== want.last) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN) begin
                        $display("%0t: exp kind=%0d byte=%02h first=%0d type=%0d forb=%0d ",
                                 $realtime, want.kind, want.data, want.first, want.utype,
                                 want.forb,
                                 "long=%0d len=%0d ovf=%0d last=%0d",
                                 want.long_sc, want.len, want.ovf, want.last);
                        $display("%0t: got kind=%0d byte=%02h first=%0d type=%0d forb=%0d ",
                                 $realtime, o_record_kind, o_payload_byte, o_first_of_unit,
                                 o_unit_type, o_forbidden_flag,
                                 "long=%0d len=%0d ovf=%0d last=%0d",
                                 o_long_start_code, o_unit_length, o_length_overflow,
                                 o_last_of_run);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d cycles without a transfer", STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        t_stream_row row;
        t_nal_rec    tail;
        int          sent;

        clear_splitter_state();
        //      byte   eos   rep             chk   n  kind  byte   len             ovf
        add_row(8'hAA, 1'b0, 1,              1'b1, 0, 1'b0, 8'h00, 0,              1'b0);
        add_row(8'h00, 1'b0, 4,              1'b1, 0, 1'b0, 8'h00, 0,              1'b0);
        add_row(8'h01, 1'b0, 1,              1'b1, 0, 1'b0, 8'h00, 0,              1'b0);
        add_row(8'hFE, 1'b0, 1,              1'b1, 1, 1'b0, 8'hFE, 0,              1'b0);
        add_row(8'hFF, 1'b0, 1,              1'b0, 0, 1'b0, 8'h00, 0,              1'b0);
        add_row(8'h00, 1'b0, 3,              1'b1, 0, 1'b0, 8'h00, 0,              1'b0);
        add_row(8'h00, 1'b0, 1,              1'b1, 1, 1'b0, 8'h00, 0,              1'b0);
        add_row(8'h01, 1'b0, 1,              1'b1, 1, 1'b1, 8'h00, 3,              1'b0);
        add_row(8'h00, 1'b0, 2,              1'b0, 0, 1'b0, 8'h00, 0,              1'b0);
        add_row(8'h01, 1'b0, 1,              1'b1, 1, 1'b1, 8'h00, 0,              1'b0);
        add_row(8'h40, 1'b0, 1,              1'b0, 0, 1'b0, 8'h00, 0,              1'b0);
        add_row(8'h00, 1'b0, 1,              1'b0, 0, 1'b0, 8'h00, 0,              1'b0);
        add_row(8'h01, 1'b0, 1,              1'b1, 2, 1'b0, 8'h01, 0,              1'b0);
        add_row(8'h00, 1'b0, 2,              1'b0, 0, 1'b0, 8'h00, 0,              1'b0);
        add_row(8'h02, 1'b0, 1,              1'b1, 3, 1'b0, 8'h02, 0,              1'b0);
        add_row(8'h00, 1'b0, 3,              1'b0, 0, 1'b0, 8'h00, 0,              1'b0);
        add_row(8'h80, 1'b0, 1,              1'b1, 4, 1'b0, 8'h80, 0,              1'b0);
        add_row(8'h00, 1'b0, 3,              1'b0, 0, 1'b0, 8'h00, 0,              1'b0);
        add_row(8'h00, 1'b1, 1,              1'b1, 5, 1'b1, 8'h00, 14,             1'b0);
        add_row(8'h00, 1'b0, 2,              1'b0, 0, 1'b0, 8'h00, 0,              1'b0);
        add_row(8'h01, 1'b1, 1,              1'b1, 0, 1'b0, 8'h00, 0,              1'b0);
        add_row(8'h55, 1'b1, 1,              1'b1, 0, 1'b0, 8'h00, 0,              1'b0);
        add_row(8'h00, 1'b0, 2,              1'b0, 0, 1'b0, 8'h00, 0,              1'b0);
        add_row(8'h01, 1'b0, 1,              1'b1, 0, 1'b0, 8'h00, 0,              1'b0);
        add_row(8'h01, 1'b0, 1,              1'b1, 1, 1'b0, 8'h01, 0,              1'b0);
        add_row(8'hAB, 1'b0, 8,              1'b1, 1, 1'b0, 8'hAB, 0,              1'b0);
        add_row(8'h00, 1'b0, 3,              1'b0, 0, 1'b0, 8'h00, 0,              1'b0);
        add_row(8'h01, 1'b0, 1,              1'b1, 1, 1'b1, 8'h00, 9,              1'b0);
        add_row(8'hFF, 1'b1, 1,              1'b1, 2, 1'b1, 8'h00, 1,              1'b0);

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stream_table[r]) begin
            row = stream_table[r];
            for (int k = 0; k < row.rep; k++) begin
                send_byte(row.sb, row.eos);
                bytes_directed++;
            end
            if (row.chk) begin
                tail = (byte_recs.size() > 0) ? byte_recs[byte_recs.size() - 1] : '0;
                if (byte_recs.size() != row.n || (row.n > 0 &&
                    (tail.kind !== row.kind || tail.data !== row.data ||
                     tail.len !== LEN_W'(row.len) || tail.ovf !== row.ovf))) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN) begin
                        $display("stream row %0d: exp %0d records, ", r, row.n,
                                 "last kind=%0d byte=%02h len=%0d ovf=%0d; ",
                                 row.kind, row.data, row.len, row.ovf,
                                 "predicted %0d", byte_recs.size());
                    end
                end
            end
        end
        drain_results();

        for (int ph = 0; ph < 4; ph++) begin
            unique case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            sent = 0;
            while (sent < PHASE_BYTES) begin
                build_chunk();
                foreach (chunk[k]) begin
                    send_byte(chunk[k], (k == chunk.size() - 1) &&
                                        ($urandom_range(99, 0) < 8));
                    sent++;
                end
            end
            bytes_random += sent;
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_recs.size() != 0) begin
            mismatches++;
            $display("%0d expected records never arrived", pending_recs.size());
        end

        $display("covered %0d stream bytes, %0d directed and %0d random, ",
                 bytes_directed + bytes_random, bytes_directed, bytes_random,
                 "over four handshake phases");
        $display("checked %0d records, %0d of them end-of-unit records; %0d mismatches",
                 recs_checked, ends_checked, mismatches);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/anbs_pkg.sv
design/anbs_front.sv
design/anbs_cmd_fifo.sv
design/anbs_back.sv
design/annexb_nal_unit_splitter.sv
tb/sv/testbench.sv
